// ===== hw/rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and codes of the segment versus prism clip test block.
// ----------------------------------------------------------------------------
package spc_pkg;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    REG_NORMAL_X     = 3'd0,
    REG_NORMAL_Y     = 3'd1,
    REG_NORMAL_Z     = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_PRISM_HEIGHT = 3'd4,
    REG_VERTEX_COUNT = 3'd5,
    REG_FIRST_AXIS   = 3'd6,
    REG_SECOND_AXIS  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [17:0] normal_x;
    logic signed [17:0] normal_y;
    logic signed [17:0] normal_z;
    logic signed [31:0] plane_offset;
    logic [30:0]        prism_height;
    logic [4:0]         vertex_count;
    logic [1:0]         first_axis;
    logic [1:0]         second_axis;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [3:0]         vertex_index;
    logic signed [31:0] vertex_u;
    logic signed [31:0] vertex_v;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } item_t;

  localparam logic signed [18:0] ONE_Q16    = 19'sd65536;
  localparam logic [17:0]        FRAC_LIMIT = 18'd131072;
  localparam logic signed [31:0] SAT_HI     = 32'sh7FFF_FFFF;

endpackage

// ===== hw/rtl/segment_prism_clip_test_core.sv =====
// ----------------------------------------------------------------------------
// segment_prism_clip_test_core
// Segment versus right prism clip test in Q16.16 fixed point.
//
// Input channel (in_valid_i / in_stall_o): cmd_i selects a vertex load or a
// segment test. Loads write one polygon vertex and give no result; tests give
// one result transaction on the output channel (out_valid_o / out_stall_i).
// Configuration is written over cfg_valid_i / cfg_ready_o; the user must
// write it only while idle, as the block itself does not enforce this.
// An input stage and a four-entry queue sit ahead of the clip sequencer, so
// transactions are taken while a test runs until the queue fills. Each edge
// and each of the two slab planes uses the shared radix-2 divider plus a
// shared multiplier. A test that misses early stops its edge walk.
// Reset clears configuration to its defaults and empties the queue; the
// vertex store holds no defined value until loaded.
// A stalled result stays in the output register; the sequencer then waits
// in its final step and the queue fills behind it.
// ----------------------------------------------------------------------------
module segment_prism_clip_test_core import spc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [3:0]         vertex_index_i,
  input  logic signed [31:0] vertex_u_i,
  input  logic signed [31:0] vertex_v_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [16:0]        entry_fraction_o,
  output logic signed [31:0] top_plane_offset_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cfg_t  cfg_q;
  item_t front_item, fifo_item;
  logic  push, full, pop, fifo_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_x     <= '0;
      cfg_q.normal_y     <= '0;
      cfg_q.normal_z     <= 18'sd65536;
      cfg_q.plane_offset <= '0;
      cfg_q.prism_height <= '0;
      cfg_q.vertex_count <= '0;
      cfg_q.first_axis   <= 2'd0;
      cfg_q.second_axis  <= 2'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_NORMAL_X:     cfg_q.normal_x     <= $signed(cfg_data_i[17:0]);
        REG_NORMAL_Y:     cfg_q.normal_y     <= $signed(cfg_data_i[17:0]);
        REG_NORMAL_Z:     cfg_q.normal_z     <= $signed(cfg_data_i[17:0]);
        REG_PLANE_OFFSET: cfg_q.plane_offset <= $signed(cfg_data_i);
        REG_PRISM_HEIGHT: cfg_q.prism_height <= cfg_data_i[30:0];
        REG_VERTEX_COUNT: cfg_q.vertex_count <= cfg_data_i[4:0];
        REG_FIRST_AXIS:   cfg_q.first_axis   <= cfg_data_i[1:0];
        REG_SECOND_AXIS:  cfg_q.second_axis  <= cfg_data_i[1:0];
        default:          cfg_q.second_axis  <= cfg_q.second_axis;
      endcase
    end
  end

  spc_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .vertex_index_i (vertex_index_i),
    .vertex_u_i     (vertex_u_i),
    .vertex_v_i     (vertex_v_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .start_z_i      (start_z_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .full_i         (full),
    .push_o         (push),
    .item_o         (front_item)
  );

  spc_fifo #(
    .DEPTH (4)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_item)
  );

  spc_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .item_valid_i       (fifo_valid),
    .item_i             (fifo_item),
    .item_pop_o         (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hit_o              (hit_o),
    .entry_fraction_o   (entry_fraction_o),
    .top_plane_offset_o (top_plane_offset_o)
  );

endmodule

// ===== hw/rtl/spc_front.sv =====
// ----------------------------------------------------------------------------
// spc_front
// Input stage: takes items, drops loads to slots beyond the store, queues rest.
// ----------------------------------------------------------------------------
module spc_front import spc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [3:0]         vertex_index_i,
  input  logic signed [31:0] vertex_u_i,
  input  logic signed [31:0] vertex_v_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic               full_i,
  output logic               push_o,
  output item_t              item_o
);

  logic  valid_q;
  item_t item_q;
  logic  accept;
  logic  keep;

  assign push_o     = valid_q && !full_i;
  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign keep       = (cmd_e'(cmd_i) == CMD_TEST) ||
                      (7'(vertex_index_i) < 7'(MAX_VERTICES));
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q             <= keep;
      item_q.cmd          <= cmd_e'(cmd_i);
      item_q.vertex_index <= vertex_index_i;
      item_q.vertex_u     <= vertex_u_i;
      item_q.vertex_v     <= vertex_v_i;
      item_q.start_x      <= start_x_i;
      item_q.start_y      <= start_y_i;
      item_q.start_z      <= start_z_i;
      item_q.dir_x        <= dir_x_i;
      item_q.dir_y        <= dir_y_i;
      item_q.dir_z        <= dir_z_i;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/spc_fifo.sv =====
// ----------------------------------------------------------------------------
// spc_fifo
// Short item queue between the input stage and the clip sequencer.
// ----------------------------------------------------------------------------
module spc_fifo import spc_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  item_t           mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        mem_q[wr_q] <= data_i;
        wr_q        <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/spc_div.sv =====
// ----------------------------------------------------------------------------
// spc_div
// Radix-2 divider with a signed Q2.16 quotient, truncating, magnitude saturated at 2.0.
// ----------------------------------------------------------------------------
module spc_div import spc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic signed [18:0] quo_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_CMP,
    D_RUN
  } state_e;

  state_e             state_q;
  logic [63:0]        an_q, ad_q, r_q;
  logic [17:0]        q_q;
  logic               neg_q;
  logic [4:0]         cnt_q;
  logic               done_q;
  logic signed [18:0] quo_q;
  logic [64:0]        r2;
  logic               ge;
  logic [17:0]        q_next;

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign r2     = {r_q, 1'b0};
  assign ge     = (r2 >= {1'b0, ad_q});
  assign q_next = {q_q[16:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            an_q    <= num_i[63] ? 64'(-num_i) : 64'(num_i);
            ad_q    <= den_i[63] ? 64'(-den_i) : 64'(den_i);
            neg_q   <= num_i[63] ^ den_i[63];
            state_q <= D_CMP;
          end
        end
        D_CMP: begin
          if ({1'b0, an_q} >= {ad_q, 1'b0}) begin
            quo_q   <= neg_q ? -$signed({1'b0, FRAC_LIMIT}) : $signed({1'b0, FRAC_LIMIT});
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else begin
            if (an_q >= ad_q) begin
              r_q <= an_q - ad_q;
              q_q <= 18'd1;
            end else begin
              r_q <= an_q;
              q_q <= 18'd0;
            end
            cnt_q   <= 5'd16;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          r_q   <= ge ? 64'(r2 - {1'b0, ad_q}) : r2[63:0];
          q_q   <= q_next;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 5'd1) begin
            quo_q   <= neg_q ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/spc_back.sv =====
// ----------------------------------------------------------------------------
// spc_back
// Clip sequencer: vertex store, slab clip, projection and edge walk.
// ----------------------------------------------------------------------------
module spc_back import spc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [16:0]        entry_fraction_o,
  output logic signed [31:0] top_plane_offset_o
);

  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_SLAB,
    ST_TFACE,
    ST_TTOP,
    ST_PROJ,
    ST_EREAD,
    ST_EDIFF,
    ST_EMUL,
    ST_EDEC,
    ST_EDIV,
    ST_OUT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return SAT_HI;
    end else if (x < -64'sd2147483647) begin
      return -SAT_HI;
    end else begin
      return x[31:0];
    end
  endfunction

  function automatic logic [1:0] clamp_axis(input logic [1:0] a);
    return (a == 2'd3) ? 2'd2 : a;
  endfunction

  logic [63:0] vmem [MAX_VERTICES];
  logic [63:0] rd_c_q, rd_n_q;

  state_e             state_q;
  logic [3:0]         k_q;
  logic [CW-1:0]      i_q;
  logic               hit_q;
  logic signed [31:0] s_q [3];
  logic signed [31:0] d_q [3];
  logic signed [55:0] along_q, above_q;
  logic signed [55:0] proj_q [4];
  logic signed [18:0] tface_q, entry_q, exit_q;
  logic signed [31:0] eu_q, ev_q, pu_q, pv_q, du_q, dv_q;
  logic signed [63:0] den_q, num_q;
  logic signed [65:0] p_q;
  logic               out_valid_q, out_hit_q;
  logic [16:0]        out_frac_q;
  logic signed [31:0] out_top_q;

  logic signed [17:0] n_arr [3];
  logic signed [32:0] mul_a, mul_b;
  logic [1:0]         ia, ib, dot_idx, m_idx, axis;
  logic [3:0]         prev;
  logic signed [55:0] src;
  logic [CW-1:0]      cnt, i1, jn;
  logic [6:0]         widx_ext;
  logic [IW-1:0]      widx;
  logic               div_start, div_done;
  logic signed [63:0] div_num, div_den;
  logic signed [18:0] div_quo, neg_tface, slab_entry, slab_exit, c_entry, c_exit;
  logic signed [47:0] h32;
  logic signed [31:0] cu, cv, nu, nv;
  logic signed [32:0] top_sum;
  logic               out_free;

  assign n_arr[0] = cfg_i.normal_x;
  assign n_arr[1] = cfg_i.normal_y;
  assign n_arr[2] = cfg_i.normal_z;
  assign ia       = clamp_axis(cfg_i.first_axis);
  assign ib       = clamp_axis(cfg_i.second_axis);
  assign h32      = $signed({1'b0, cfg_i.prism_height, 16'b0});
  assign cnt      = (7'(cfg_i.vertex_count) > 7'(MAX_VERTICES)) ?
                    CW'(MAX_VERTICES) : CW'(cfg_i.vertex_count);
  assign i1       = i_q + 1'b1;
  assign jn       = (i1 < cnt) ? i1 : '0;
  assign widx_ext = 7'(item_i.vertex_index);
  assign widx     = widx_ext[IW-1:0];
  assign cu       = $signed(rd_c_q[63:32]);
  assign cv       = $signed(rd_c_q[31:0]);
  assign nu       = $signed(rd_n_q[63:32]);
  assign nv       = $signed(rd_n_q[31:0]);
  assign top_sum  = 33'(cfg_i.plane_offset) + $signed({2'b0, cfg_i.prism_height});
  assign out_free = !out_valid_q || !out_stall_i;
  assign prev     = k_q - 4'd1;
  assign dot_idx  = (k_q < 4'd3) ? k_q[1:0] : 2'(k_q - 4'd3);
  assign m_idx    = k_q[2:1];
  assign axis     = m_idx[1] ? ib : ia;
  assign src      = m_idx[0] ? along_q : above_q;
  assign neg_tface = -tface_q;

  assign item_pop_o         = (state_q == ST_IDLE) && item_valid_i;
  assign out_valid_o        = out_valid_q;
  assign hit_o              = out_hit_q;
  assign entry_fraction_o   = out_frac_q;
  assign top_plane_offset_o = out_top_q;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DOT: begin
        if (k_q < 4'd6) begin
          mul_a = 33'(n_arr[dot_idx]);
          mul_b = (k_q < 4'd3) ? 33'(d_q[dot_idx]) : 33'(s_q[dot_idx]);
        end
      end
      ST_PROJ: begin
        if (k_q < 4'd8) begin
          mul_a = 33'(n_arr[axis]);
          mul_b = k_q[0] ? $signed({17'b0, src[31:16]}) : 33'($signed(src[55:32]));
        end
      end
      ST_EMUL: begin
        unique case (k_q)
          4'd0: begin
            mul_a = 33'(ev_q);
            mul_b = 33'(du_q);
          end
          4'd1: begin
            mul_a = 33'(dv_q);
            mul_b = 33'(eu_q);
          end
          4'd2: begin
            mul_a = 33'(pv_q);
            mul_b = 33'(eu_q);
          end
          4'd3: begin
            mul_a = 33'(ev_q);
            mul_b = 33'(pu_q);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider requests
  always_comb begin
    div_start = 1'b0;
    div_num   = 64'(above_q);
    div_den   = 64'(along_q);
    unique case (state_q)
      ST_SLAB: begin
        div_start = (along_q != '0);
      end
      ST_TFACE: begin
        div_start = div_done;
        div_num   = 64'(h32) - 64'(above_q);
      end
      ST_EDEC: begin
        div_start = (den_q != '0);
        div_num   = num_q;
        div_den   = den_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // slab and edge interval updates
  always_comb begin
    if (along_q[55]) begin
      slab_entry = (div_quo > 19'sd0) ? div_quo : 19'sd0;
      slab_exit  = (neg_tface < ONE_Q16) ? neg_tface : ONE_Q16;
    end else begin
      slab_entry = (neg_tface > 19'sd0) ? neg_tface : 19'sd0;
      slab_exit  = (div_quo < ONE_Q16) ? div_quo : ONE_Q16;
    end
    c_entry = entry_q;
    c_exit  = exit_q;
    if (den_q > 64'sd0) begin
      c_exit = (exit_q > div_quo) ? div_quo : exit_q;
    end else begin
      c_entry = (entry_q < div_quo) ? div_quo : entry_q;
    end
  end

  spc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (item_pop_o && item_i.cmd == CMD_LOAD) begin
      vmem[widx] <= {item_i.vertex_u, item_i.vertex_v};
    end
    rd_c_q <= vmem[i_q[IW-1:0]];
    rd_n_q <= vmem[jn[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      i_q         <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p_q <= mul_a * mul_b;
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i && item_i.cmd == CMD_TEST) begin
            s_q[0]  <= item_i.start_x;
            s_q[1]  <= item_i.start_y;
            s_q[2]  <= item_i.start_z;
            d_q[0]  <= item_i.dir_x;
            d_q[1]  <= item_i.dir_y;
            d_q[2]  <= item_i.dir_z;
            along_q <= '0;
            above_q <= -56'($signed({cfg_i.plane_offset, 16'b0}));
            k_q     <= '0;
            state_q <= ST_DOT;
          end
        end
        ST_DOT: begin
          if (k_q != 4'd0) begin
            if (k_q < 4'd4) begin
              along_q <= along_q + p_q[55:0];
            end else begin
              above_q <= above_q + p_q[55:0];
            end
          end
          k_q <= k_q + 1'b1;
          if (k_q == 4'd6) begin
            state_q <= ST_SLAB;
          end
        end
        ST_SLAB: begin
          entry_q   <= '0;
          exit_q    <= ONE_Q16;
          k_q       <= '0;
          i_q       <= '0;
          proj_q[0] <= 56'(s_q[ia]);
          proj_q[1] <= 56'(d_q[ia]);
          proj_q[2] <= 56'(s_q[ib]);
          proj_q[3] <= 56'(d_q[ib]);
          if (along_q != '0) begin
            state_q <= ST_TFACE;
          end else begin
            hit_q   <= !above_q[55] && (above_q < 56'(h32));
            state_q <= (!above_q[55] && (above_q < 56'(h32))) ? ST_PROJ : ST_OUT;
          end
        end
        ST_TFACE: begin
          if (div_done) begin
            tface_q <= div_quo;
            state_q <= ST_TTOP;
          end
        end
        ST_TTOP: begin
          if (div_done) begin
            entry_q <= slab_entry;
            exit_q  <= slab_exit;
            hit_q   <= (slab_entry <= slab_exit);
            state_q <= (slab_entry <= slab_exit) ? ST_PROJ : ST_OUT;
          end
        end
        ST_PROJ: begin
          if (k_q != 4'd0) begin
            proj_q[prev[2:1]] <= proj_q[prev[2:1]] -
                                 (prev[0] ? 56'(p_q >>> 16) : p_q[55:0]);
          end
          k_q <= k_q + 1'b1;
          if (k_q == 4'd8) begin
            state_q <= (cnt == '0) ? ST_OUT : ST_EREAD;
          end
        end
        ST_EREAD: begin
          state_q <= ST_EDIFF;
        end
        ST_EDIFF: begin
          eu_q    <= sat32(64'(nu) - 64'(cu));
          ev_q    <= sat32(64'(nv) - 64'(cv));
          pu_q    <= sat32(64'(proj_q[0]) - 64'(cu));
          pv_q    <= sat32(64'(proj_q[2]) - 64'(cv));
          du_q    <= sat32(64'(proj_q[1]));
          dv_q    <= sat32(64'(proj_q[3]));
          k_q     <= '0;
          state_q <= ST_EMUL;
        end
        ST_EMUL: begin
          unique case (k_q)
            4'd1: den_q <= p_q[63:0];
            4'd2: den_q <= den_q - p_q[63:0];
            4'd3: num_q <= p_q[63:0];
            4'd4: num_q <= num_q - p_q[63:0];
            default: begin
            end
          endcase
          k_q <= k_q + 1'b1;
          if (k_q == 4'd4) begin
            state_q <= ST_EDEC;
          end
        end
        ST_EDEC: begin
          if (den_q != '0) begin
            state_q <= ST_EDIV;
          end else if (num_q < 0) begin
            hit_q   <= 1'b0;
            state_q <= ST_OUT;
          end else if (i1 == cnt) begin
            state_q <= ST_OUT;
          end else begin
            i_q     <= i1;
            state_q <= ST_EREAD;
          end
        end
        ST_EDIV: begin
          if (div_done) begin
            entry_q <= c_entry;
            exit_q  <= c_exit;
            if (c_entry > c_exit) begin
              hit_q   <= 1'b0;
              state_q <= ST_OUT;
            end else if (i1 == cnt) begin
              state_q <= ST_OUT;
            end else begin
              i_q     <= i1;
              state_q <= ST_EREAD;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            out_frac_q  <= hit_q ? entry_q[16:0] : '0;
            if (!hit_q) begin
              out_top_q <= '0;
            end else if (top_sum > 33'(SAT_HI)) begin
              out_top_q <= SAT_HI;
            end else begin
              out_top_q <= top_sum[31:0];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/segment_prism_clip_test_core_tb.sv =====
// ----------------------------------------------------------------------------
// segment_prism_clip_test_core_tb
// Self-checking bench for the segment versus prism clip test block. A queue
// fed driver sends vertex loads and segment tests and keeps its own Q16.16
// clip calculation, and a monitor compares each result transaction in order.
// Configuration changes between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_prism_clip_test_core_tb;
  import spc_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [16:0] frac;
    logic [31:0] top;
  } clip_res_t;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam longint Q1 = 65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  item_t item_r = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_stall_o, out_valid_o, hit_o, cfg_ready_o;
  logic [16:0] entry_fraction_o;
  logic signed [31:0] top_plane_offset_o;

  item_t pending_q[$];
  clip_res_t clip_expect_q[$];
  cfg_t model_cfg;
  longint vert_u[16], vert_v[16];
  int unsigned cycle_cnt = 0, sent_cnt = 0, result_cnt = 0, hit_cnt = 0;
  int unsigned load_cnt = 0, err_cnt = 0, hold_left = 0;
  bit hold_done = 1'b0;

  always #10 clk_i = ~clk_i;

  segment_prism_clip_test_core DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o,
    .cmd_i(item_r.cmd), .vertex_index_i(item_r.vertex_index),
    .vertex_u_i(item_r.vertex_u), .vertex_v_i(item_r.vertex_v),
    .start_x_i(item_r.start_x), .start_y_i(item_r.start_y), .start_z_i(item_r.start_z),
    .dir_x_i(item_r.dir_x), .dir_y_i(item_r.dir_y), .dir_z_i(item_r.dir_z),
    .out_valid_o, .out_stall_i(out_stall),
    .hit_o, .entry_fraction_o, .top_plane_offset_o,
    .cfg_valid_i(cfg_valid), .cfg_ready_o, .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic longint sat31(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483647) return -64'sd2147483647;
    return x;
  endfunction

  // Q16.16 quotient, truncated toward zero, magnitude capped at 2.0
  function automatic longint frac_div(longint num, longint den);
    bit [63:0] an, ad, q, r;
    longint mag;
    an = num < 0 ? 64'd0 - 64'(num) : 64'(num);
    ad = den < 0 ? 64'd0 - 64'(den) : 64'(den);
    if (an >= (ad << 1)) begin
      mag = 131072;
    end else begin
      q = an >= ad ? 64'd1 : 64'd0;
      r = an - (q != 0 ? ad : 64'd0);
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ad) begin
          r = r - ad;
          q[0] = 1'b1;
        end
      end
      mag = longint'(q);
    end
    return ((num < 0) != (den < 0)) ? -mag : mag;
  endfunction

  function automatic clip_res_t clip_predict(item_t it);
    longint n[3], s[3], d[3], pp[3], dp[3];
    longint along, above, h32, t_in, t_out, a16, l16, tface, ttop, top;
    longint cu, cv, eu, ev, pu, pv, du, dv, den, num, c;
    int cnt, ia, ib, j;
    bit hit;
    clip_res_t r;
    t_in = 0;
    t_out = Q1;
    hit = 1'b1;
    n[0] = longint'(model_cfg.normal_x);
    n[1] = longint'(model_cfg.normal_y);
    n[2] = longint'(model_cfg.normal_z);
    s[0] = longint'(it.start_x); s[1] = longint'(it.start_y); s[2] = longint'(it.start_z);
    d[0] = longint'(it.dir_x); d[1] = longint'(it.dir_y); d[2] = longint'(it.dir_z);
    along = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
    above = n[0] * s[0] + n[1] * s[1] + n[2] * s[2] - longint'(model_cfg.plane_offset) * Q1;
    h32 = longint'(model_cfg.prism_height) * Q1;
    if (along == 0) begin
      if (above < 0 || above >= h32) hit = 1'b0;
    end else begin
      tface = frac_div(above, along);
      ttop = frac_div(h32 - above, along);
      if (along < 0) begin
        if (ttop > 0) t_in = ttop;
        if (-tface < Q1) t_out = -tface;
      end else begin
        if (-tface > 0) t_in = -tface;
        if (ttop < Q1) t_out = ttop;
      end
      if (t_in > t_out) hit = 1'b0;
    end
    if (hit) begin
      cnt = model_cfg.vertex_count > 16 ? 16 : model_cfg.vertex_count;
      ia = model_cfg.first_axis > 2 ? 2 : model_cfg.first_axis;
      ib = model_cfg.second_axis > 2 ? 2 : model_cfg.second_axis;
      a16 = above >>> 16;
      l16 = along >>> 16;
      for (int k = 0; k < 3; k++) begin
        pp[k] = s[k] - ((n[k] * a16) >>> 16);
        dp[k] = d[k] - ((n[k] * l16) >>> 16);
      end
      for (int i = 0; i < cnt && hit; i++) begin
        j = (i + 1 < cnt) ? i + 1 : 0;
        cu = vert_u[i];
        cv = vert_v[i];
        eu = sat31(vert_u[j] - cu);
        ev = sat31(vert_v[j] - cv);
        pu = sat31(pp[ia] - cu);
        pv = sat31(pp[ib] - cv);
        du = sat31(dp[ia]);
        dv = sat31(dp[ib]);
        den = ev * du - dv * eu;
        num = pv * eu - ev * pu;
        if (den == 0) begin
          if (num < 0) hit = 1'b0;
        end else begin
          c = frac_div(num, den);
          if (den > 0) begin
            if (t_out > c) t_out = c;
          end else if (t_in < c) begin
            t_in = c;
          end
          if (t_in > t_out) hit = 1'b0;
        end
      end
    end
    r = '0;
    if (hit) begin
      top = longint'(model_cfg.plane_offset) + longint'(model_cfg.prism_height);
      if (top > 64'sd2147483647) top = 64'sd2147483647;
      r.hit = 1'b1;
      r.frac = t_in[16:0];
      r.top = top[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        sent_cnt++;
        if (item_r.cmd == CMD_LOAD) begin
          vert_u[item_r.vertex_index] = longint'(item_r.vertex_u);
          vert_v[item_r.vertex_index] = longint'(item_r.vertex_v);
          load_cnt++;
        end else begin
          clip_expect_q.push_back(clip_predict(item_r));
        end
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_q.size() != 0 &&
            ((sent_cnt > 400 && sent_cnt < 560) || $urandom_range(99) >= 16)) begin
          item_r <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        result_cnt++;
        if (clip_expect_q.size() == 0) begin
          report_mismatch("unexpected transaction", {31'd0, hit_o}, 32'd0);
        end else begin
          clip_res_t w;
          w = clip_expect_q.pop_front();
          if (w.hit) hit_cnt++;
          if (hit_o !== w.hit) report_mismatch("hit", {31'd0, hit_o}, {31'd0, w.hit});
          if (entry_fraction_o !== w.frac)
            report_mismatch("entry_fraction", {15'd0, entry_fraction_o}, {15'd0, w.frac});
          if (top_plane_offset_o !== w.top)
            report_mismatch("top_plane_offset", top_plane_offset_o, w.top);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (result_cnt >= 150 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 600;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(result_cnt > 250 && result_cnt < 350) && $urandom_range(99) < 16;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic item_t mk_load(logic [3:0] idx, logic [31:0] u, logic [31:0] v);
    item_t it;
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.cmd = CMD_LOAD;
    it.vertex_index = idx;
    it.vertex_u = u;
    it.vertex_v = v;
    return it;
  endfunction

  function automatic item_t mk_test(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                    logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    item_t it;
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.cmd = CMD_TEST;
    it.start_x = sx; it.start_y = sy; it.start_z = sz;
    it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
    return it;
  endfunction

  function automatic logic [31:0] rnd_q(int unsigned span);
    return 32'($signed($urandom_range(2 * span)) - $signed(span));
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid || clip_expect_q.size() != 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      REG_NORMAL_X:     model_cfg.normal_x = data[17:0];
      REG_NORMAL_Y:     model_cfg.normal_y = data[17:0];
      REG_NORMAL_Z:     model_cfg.normal_z = data[17:0];
      REG_PLANE_OFFSET: model_cfg.plane_offset = data;
      REG_PRISM_HEIGHT: model_cfg.prism_height = data[30:0];
      REG_VERTEX_COUNT: model_cfg.vertex_count = data[4:0];
      REG_FIRST_AXIS:   model_cfg.first_axis = data[1:0];
      REG_SECOND_AXIS:  model_cfg.second_axis = data[1:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz, logic [31:0] po,
                         logic [31:0] ph, logic [31:0] vc, logic [31:0] fa, logic [31:0] sa);
    wait_drained();
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_PLANE_OFFSET, po);
    write_reg(REG_PRISM_HEIGHT, ph);
    write_reg(REG_VERTEX_COUNT, vc);
    write_reg(REG_FIRST_AXIS, fa);
    write_reg(REG_SECOND_AXIS, sa);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned vc, kind;
    logic [31:0] a1, a2, b1, b2, nx, ny, nz;
    model_cfg = '0;
    model_cfg.normal_z = 18'sd65536;
    model_cfg.second_axis = 2'd1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // square of side 4.0 in slots 0..3, extreme coordinates in the rest
    pending_q.push_back(mk_load(4'd0, 32'd0, 32'd0));
    pending_q.push_back(mk_load(4'd1, 32'h0004_0000, 32'd0));
    pending_q.push_back(mk_load(4'd2, 32'h0004_0000, 32'h0004_0000));
    pending_q.push_back(mk_load(4'd3, 32'd0, 32'h0004_0000));
    for (int i = 4; i < 16; i++)
      pending_q.push_back(mk_load(4'(i), i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                                  i[1] ? 32'h7FFF_FFFF : 32'h8000_0000));
    // zero height: parallel segment lies outside the slab
    pending_q.push_back(mk_test(32'h0002_0000, 32'h0002_0000, 32'd0, 32'h0001_0000, 0, 0));

    set_cfg(0, 0, 32'h0001_0000, 0, 32'h0004_0000, 4, 0, 1);
    pending_q.push_back(mk_test(32'h0002_0000, 32'h0002_0000, 32'hFFFE_0000, 0, 0,
                                32'h0008_0000));
    pending_q.push_back(mk_test(32'h0006_0000, 32'h0002_0000, 32'hFFFE_0000, 0, 0,
                                32'h0008_0000));
    pending_q.push_back(mk_test(32'h0002_0000, 32'h0002_0000, 32'h0001_0000,
                                32'h0001_0000, 0, 0));
    pending_q.push_back(mk_test(32'h0006_0000, 32'h0002_0000, 32'h0001_0000, 0,
                                32'h0001_0000, 0));
    pending_q.push_back(mk_test(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 0, 0, 0));
    pending_q.push_back(mk_test(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));

    set_cfg(32'h0002_0000, 32'h0003_0000, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            16, 3, 3);
    pending_q.push_back(mk_test(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_q.push_back(mk_test(0, 0, 0, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000));

    set_cfg(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            31, 2, 0);
    pending_q.push_back(mk_test(32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                                32'h7FFF_FFFF));
    pending_q.push_back(mk_test(0, 32'h7FFF_FFFF, 0, 32'h0001_0000, 32'h8000_0000, 0));

    set_cfg(0, 0, 32'h0001_0000, 0, 32'h0004_0000, 1, 0, 1);
    pending_q.push_back(mk_test(0, 0, 32'hFFFF_0000, 0, 0, 32'h0004_0000));
    set_cfg(0, 0, 32'h0001_0000, 0, 32'h0004_0000, 2, 0, 1);
    pending_q.push_back(mk_test(32'h0002_0000, 0, 32'hFFFF_0000, 0, 0, 32'h0004_0000));

    for (int p = 0; p < 10; p++) begin
      kind = p % 4;
      vc = (p == 7) ? 16 : $urandom_range(3, 6);
      case (kind)
        0: begin nx = 0; ny = 0; nz = 32'h0001_0000; end
        1: begin nx = 32'h0001_0000; ny = 0; nz = 0; end
        2: begin nx = 0; ny = 0; nz = 32'hFFFF_0000; end
        default: begin
          nx = rnd_q(65536); ny = rnd_q(65536); nz = rnd_q(65536);
        end
      endcase
      if (p == 9)
        set_cfg(nx, ny, nz, 32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(31), 3,
                $urandom_range(3));
      else
        set_cfg(nx, ny, nz, rnd_q(2 << 16), $urandom_range(8 << 16), vc,
                kind == 1 ? 1 : $urandom_range(2), kind == 1 ? 2 : $urandom_range(2));
      a1 = rnd_q(4 << 16); a2 = rnd_q(4 << 16); b1 = rnd_q(4 << 16); b2 = rnd_q(4 << 16);
      pending_q.push_back(mk_load(4'd0, a1, a2));
      pending_q.push_back(mk_load(4'd1, b1, a2));
      pending_q.push_back(mk_load(4'd2, b1, b2));
      pending_q.push_back(mk_load(4'd3, a1, b2));
      for (int i = 4; i < 16; i++)
        pending_q.push_back(mk_load(4'(i), rnd_q(6 << 16), rnd_q(6 << 16)));
      for (int i = 0; i < 90; i++) begin
        if (p == 4 && i == 45) wait_drained();
        case ($urandom_range(19))
          0: pending_q.push_back(mk_load(4'($urandom_range(4, 15)), $urandom, $urandom));
          1, 2, 3, 4:
            pending_q.push_back(mk_test($urandom, $urandom, $urandom, $urandom, $urandom,
                                        $urandom));
          default:
            pending_q.push_back(mk_test(rnd_q(6 << 16), rnd_q(6 << 16), rnd_q(6 << 16),
                                        rnd_q(12 << 16), rnd_q(12 << 16), rnd_q(12 << 16)));
        endcase
      end
    end

    wait_drained();
    repeat (400) @(posedge clk_i);
    $display("sent %0d transactions (%0d vertex loads), checked %0d results, %0d hits",
             sent_cnt, load_cnt, result_cnt, hit_cnt);
    $display("covered slab-only, degenerate, saturating and axis-remapped configurations");
    if (err_cnt == 0 && clip_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, clip_expect_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
